// File: rtl/grid_maze_generator_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid maze generator
// ----------------------------------------------------------------------------
`ifndef GRID_MAZE_GENERATOR_TOP_DEFINES_SVH
`define GRID_MAZE_GENERATOR_TOP_DEFINES_SVH

// condition holds on every clock edge outside reset
`define GMG_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define GMG_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define GMG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/gmg_pkg.sv
// ----------------------------------------------------------------------------
// gmg_pkg
// Shared types and codes of the grid maze generator.
// ----------------------------------------------------------------------------
package gmg_pkg;

    localparam int CFG_DW = 7;
    localparam int RV_W   = 16;
    localparam int POS_W  = 6;

    localparam logic [1:0] CFG_MAZE_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_MAZE_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_ALGORITHM_MODE = 2'd2;

    localparam logic [CFG_DW-1:0] WIDTH_RESET  = 7'd31;
    localparam logic [CFG_DW-1:0] HEIGHT_RESET = 7'd31;
    localparam logic              MODE_RESET   = 1'b0;

    localparam int MARK_PATH    = 0;
    localparam int MARK_VISITED = 1;

    localparam logic MODE_DFS  = 1'b0;
    localparam logic MODE_PRIM = 1'b1;

    typedef enum logic [1:0] {
        OP_STEP    = 2'd0,
        OP_RESTART = 2'd1,
        OP_READ    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_E = 2'd1,
        DIR_S = 2'd2,
        DIR_W = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        JOB_INIT,
        JOB_DFS,
        JOB_PRIM
    } job_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_INIT,
        ST_IDLE,
        ST_DFS_TOP,
        ST_NB_ISSUE,
        ST_NB_CHECK,
        ST_DUP_ISSUE,
        ST_DUP_CHECK,
        ST_SCAN_END,
        ST_MOD_WAIT,
        ST_PRIM_EDGE,
        ST_SHIFT_ISSUE,
        ST_SHIFT_WR,
        ST_PRIM_CHK,
        ST_CARVE,
        ST_CARVE_WALL,
        ST_PURGE_ISSUE,
        ST_PURGE_MARK,
        ST_PURGE_KEEP,
        ST_READ,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0] read_row;
        logic [POS_W-1:0] read_column;
        logic [RV_W-1:0]  random_value;
        logic [1:0]       opcode;
    } item_t;

    typedef struct packed {
        logic             cell_is_path;
        logic             complete;
        logic             backtracked;
        logic [POS_W-1:0] wall_row;
        logic [POS_W-1:0] wall_column;
        logic [POS_W-1:0] new_row;
        logic [POS_W-1:0] new_column;
        logic             carved;
    } result_t;

    typedef struct packed {
        logic              algorithm_mode;
        logic [CFG_DW-1:0] maze_height;
        logic [CFG_DW-1:0] maze_width;
    } cfg_t;

endpackage

// File: rtl/gmg_mod.sv
// ----------------------------------------------------------------------------
// gmg_mod
// Restoring remainder unit: one quotient bit per cycle over the 16-bit value.
// ----------------------------------------------------------------------------
module gmg_mod #(
    parameter int DW = 11
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [gmg_pkg::RV_W-1:0]     dividend,
    input  logic [DW-1:0]                divisor,
    output logic                         done,
    output logic [DW-1:0]                remainder
);

    localparam int CNT_W = $clog2(gmg_pkg::RV_W + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [gmg_pkg::RV_W-1:0] dvd_reg, dvd_next;
    logic [DW-1:0]            div_reg, div_next;
    logic [DW-1:0]            rem_reg, rem_next;
    logic [DW:0]              trial;

    assign trial = {rem_reg, dvd_reg[gmg_pkg::RV_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(gmg_pkg::RV_W);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = DW'(trial - {1'b0, div_reg});
            end else begin
                rem_next = DW'(trial);
            end
            dvd_next = {dvd_reg[gmg_pkg::RV_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/gmg_core.sv
// ----------------------------------------------------------------------------
// gmg_core
// Sequencer over the cell mark, path stack and frontier memories.
// ----------------------------------------------------------------------------
`include "grid_maze_generator_top_defines.svh"

module gmg_core #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int LIST_DEPTH  = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  gmg_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  gmg_pkg::item_t   in_item,
    output logic             res_valid,
    input  logic             out_free,
    output gmg_pkg::result_t res_out
);

    localparam int CW     = $clog2(MAX_COLUMNS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int ACW    = $clog2(MAX_COLUMNS + 1);
    localparam int ARW    = $clog2(MAX_ROWS + 1);
    localparam int NCELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int AW     = $clog2(NCELLS);
    localparam int LIW    = $clog2(LIST_DEPTH);
    localparam int LCW    = $clog2(LIST_DEPTH + 1);

    typedef struct packed {
        gmg_pkg::dir_t dir;
        logic [RW-1:0] row;
        logic [CW-1:0] col;
    } fedge_t;

    typedef struct packed {
        logic          ok;
        logic [RW-1:0] row;
        logic [CW-1:0] col;
    } nb_t;

    function automatic nb_t neighbor(input logic [CW-1:0] c, input logic [RW-1:0] r,
                                     input gmg_pkg::dir_t d, input logic [ACW-1:0] ac,
                                     input logic [ARW-1:0] ar);
        nb_t          n;
        logic [ACW:0] ce;
        logic [ARW:0] re;
        ce    = (ACW+1)'(c) + (ACW+1)'(2);
        re    = (ARW+1)'(r) + (ARW+1)'(2);
        n.ok  = 1'b0;
        n.col = c;
        n.row = r;
        case (d)
            gmg_pkg::DIR_N: begin
                n.ok  = (r >= RW'(2));
                n.row = r - RW'(2);
            end
            gmg_pkg::DIR_E: begin
                n.ok  = (ce < {1'b0, ac});
                n.col = CW'(ce);
            end
            gmg_pkg::DIR_S: begin
                n.ok  = (re < {1'b0, ar});
                n.row = RW'(re);
            end
            gmg_pkg::DIR_W: begin
                n.ok  = (c >= CW'(2));
                n.col = c - CW'(2);
            end
            default: n.ok = 1'b0;
        endcase
        return n;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                                input logic [RW-1:0] r);
        return AW'((AW+1)'(r) * (AW+1)'(MAX_COLUMNS) + (AW+1)'(c));
    endfunction

    function automatic logic [ACW-1:0] clamp_cols(input logic [gmg_pkg::CFG_DW-1:0] w);
        if (w < gmg_pkg::CFG_DW'(3)) begin
            return ACW'(3);
        end else if (int'(w) > MAX_COLUMNS) begin
            return ACW'(MAX_COLUMNS);
        end else begin
            return ACW'(w);
        end
    endfunction

    function automatic logic [ARW-1:0] clamp_rows(input logic [gmg_pkg::CFG_DW-1:0] h);
        if (h < gmg_pkg::CFG_DW'(3)) begin
            return ARW'(3);
        end else if (int'(h) > MAX_ROWS) begin
            return ARW'(MAX_ROWS);
        end else begin
            return ARW'(h);
        end
    endfunction

    // memories
    logic [1:0]       mark_mem [NCELLS];
    logic [CW+RW-1:0] stack_mem [LIST_DEPTH];
    fedge_t           front_mem [LIST_DEPTH];

    logic             mk_we;
    logic [AW-1:0]    mk_waddr, mk_raddr;
    logic [1:0]       mk_wdata, mk_rdata_reg;
    logic             st_we;
    logic [LIW-1:0]   st_waddr, st_raddr;
    logic [CW+RW-1:0] st_wdata, st_rdata_reg;
    logic             fr_we;
    logic [LIW-1:0]   fr_waddr, fr_raddr;
    fedge_t           fr_wdata, fr_rdata_reg;

    always_ff @(posedge aclk) begin
        if (mk_we) begin
            mark_mem[mk_waddr] <= mk_wdata;
        end
        mk_rdata_reg <= mark_mem[mk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            stack_mem[st_waddr] <= st_wdata;
        end
        st_rdata_reg <= stack_mem[st_raddr];
    end

    always_ff @(posedge aclk) begin
        if (fr_we) begin
            front_mem[fr_waddr] <= fr_wdata;
        end
        fr_rdata_reg <= front_mem[fr_raddr];
    end

    // remainder unit
    logic                     mod_start;
    logic [gmg_pkg::RV_W-1:0] mod_dividend;
    logic [LCW-1:0]           mod_divisor;
    logic                     mod_done;
    logic [LCW-1:0]           mod_rem;

    gmg_mod #(
        .DW (LCW)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // registers
    gmg_pkg::state_t  state_reg, state_next;
    gmg_pkg::job_t    job_reg, job_next;
    logic             from_reset_reg, from_reset_next;
    logic [ACW-1:0]   act_cols_reg, act_cols_next;
    logic [ARW-1:0]   act_rows_reg, act_rows_next;
    logic             act_mode_reg, act_mode_next;
    logic [LCW-1:0]   depth_reg, depth_next;
    logic [LCW-1:0]   fcount_reg, fcount_next;
    logic             done_reg, done_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [CW-1:0]    cur_c_reg, cur_c_next;
    logic [RW-1:0]    cur_r_reg, cur_r_next;
    gmg_pkg::dir_t    dir_reg, dir_next;
    logic [2:0]       ncand_reg, ncand_next;
    gmg_pkg::dir_t    cand_reg [4];
    gmg_pkg::dir_t    cand_next [4];
    logic [CW-1:0]    tgt_c_reg, tgt_c_next;
    logic [RW-1:0]    tgt_r_reg, tgt_r_next;
    gmg_pkg::dir_t    tdir_reg, tdir_next;
    logic [gmg_pkg::RV_W-1:0] rv_reg, rv_next;
    logic [LCW-1:0]   idx_reg, idx_next;
    logic [LCW-1:0]   kept_reg, kept_next;
    fedge_t           edge_reg, edge_next;
    logic             rd_ok_reg, rd_ok_next;
    gmg_pkg::result_t res_reg, res_next;

    // shared terms
    logic             in_fire;
    nb_t              nb, nb_pick;
    gmg_pkg::dir_t    pick_dir;
    logic             mk_free;
    logic             dir_last;
    logic             dup_hit;
    logic             idx_lt;
    logic [LCW-1:0]   idx_dec, depth_dec;
    logic [CW-1:0]    wall_c;
    logic [RW-1:0]    wall_r;
    logic             rd_in_grid;
    gmg_pkg::state_t  adv_state;

    assign in_ready   = (state_reg == gmg_pkg::ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign nb         = neighbor(cur_c_reg, cur_r_reg, dir_reg, act_cols_reg, act_rows_reg);
    assign pick_dir   = cand_reg[mod_rem[1:0]];
    assign nb_pick    = neighbor(cur_c_reg, cur_r_reg, pick_dir, act_cols_reg, act_rows_reg);
    assign mk_free    = !mk_rdata_reg[gmg_pkg::MARK_VISITED];
    assign dir_last   = (dir_reg == gmg_pkg::DIR_W);
    assign dup_hit    = (fr_rdata_reg.col == nb.col) && (fr_rdata_reg.row == nb.row);
    assign idx_lt     = (idx_reg < fcount_reg);
    assign idx_dec    = idx_reg - LCW'(1);
    assign depth_dec  = depth_reg - LCW'(1);
    assign adv_state  = dir_last ? gmg_pkg::ST_SCAN_END : gmg_pkg::ST_NB_ISSUE;
    assign rd_in_grid = ({1'b0, in_item.read_column} < (gmg_pkg::POS_W+ACW)'(act_cols_reg))
                     && ({1'b0, in_item.read_row} < (gmg_pkg::POS_W+ARW)'(act_rows_reg));

    always_comb begin
        wall_c = tgt_c_reg;
        wall_r = tgt_r_reg;
        case (tdir_reg)
            gmg_pkg::DIR_N: wall_r = tgt_r_reg + RW'(1);
            gmg_pkg::DIR_E: wall_c = tgt_c_reg - CW'(1);
            gmg_pkg::DIR_S: wall_r = tgt_r_reg - RW'(1);
            gmg_pkg::DIR_W: wall_c = tgt_c_reg + CW'(1);
            default: wall_c = tgt_c_reg;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gmg_pkg::ST_CLEAR: begin
                if (clr_reg == AW'(NCELLS - 1)) begin
                    state_next = gmg_pkg::ST_INIT;
                end
            end
            gmg_pkg::ST_INIT: state_next = gmg_pkg::ST_NB_ISSUE;
            gmg_pkg::ST_IDLE: begin
                if (in_fire) begin
                    case (in_item.opcode)
                        gmg_pkg::OP_STEP: begin
                            if (done_reg) begin
                                state_next = gmg_pkg::ST_FINISH;
                            end else if (act_mode_reg == gmg_pkg::MODE_DFS) begin
                                state_next = (depth_reg == '0) ? gmg_pkg::ST_FINISH
                                                               : gmg_pkg::ST_DFS_TOP;
                            end else begin
                                state_next = (fcount_reg == '0) ? gmg_pkg::ST_FINISH
                                                                : gmg_pkg::ST_MOD_WAIT;
                            end
                        end
                        gmg_pkg::OP_RESTART: state_next = gmg_pkg::ST_CLEAR;
                        gmg_pkg::OP_READ:    state_next = gmg_pkg::ST_READ;
                        default:             state_next = gmg_pkg::ST_FINISH;
                    endcase
                end
            end
            gmg_pkg::ST_DFS_TOP: state_next = gmg_pkg::ST_NB_ISSUE;
            gmg_pkg::ST_NB_ISSUE: begin
                state_next = nb.ok ? gmg_pkg::ST_NB_CHECK : adv_state;
            end
            gmg_pkg::ST_NB_CHECK: begin
                if (mk_free && job_reg != gmg_pkg::JOB_DFS) begin
                    state_next = gmg_pkg::ST_DUP_ISSUE;
                end else begin
                    state_next = adv_state;
                end
            end
            gmg_pkg::ST_DUP_ISSUE: begin
                state_next = idx_lt ? gmg_pkg::ST_DUP_CHECK : adv_state;
            end
            gmg_pkg::ST_DUP_CHECK: begin
                state_next = dup_hit ? adv_state : gmg_pkg::ST_DUP_ISSUE;
            end
            gmg_pkg::ST_SCAN_END: begin
                case (job_reg)
                    gmg_pkg::JOB_DFS: begin
                        state_next = (ncand_reg == '0) ? gmg_pkg::ST_FINISH
                                                       : gmg_pkg::ST_MOD_WAIT;
                    end
                    gmg_pkg::JOB_PRIM: state_next = gmg_pkg::ST_PURGE_ISSUE;
                    default: begin
                        state_next = from_reset_reg ? gmg_pkg::ST_IDLE : gmg_pkg::ST_FINISH;
                    end
                endcase
            end
            gmg_pkg::ST_MOD_WAIT: begin
                if (mod_done) begin
                    state_next = (job_reg == gmg_pkg::JOB_DFS) ? gmg_pkg::ST_CARVE
                                                               : gmg_pkg::ST_PRIM_EDGE;
                end
            end
            gmg_pkg::ST_PRIM_EDGE: state_next = gmg_pkg::ST_SHIFT_ISSUE;
            gmg_pkg::ST_SHIFT_ISSUE: begin
                state_next = idx_lt ? gmg_pkg::ST_SHIFT_WR : gmg_pkg::ST_PRIM_CHK;
            end
            gmg_pkg::ST_SHIFT_WR: state_next = gmg_pkg::ST_SHIFT_ISSUE;
            gmg_pkg::ST_PRIM_CHK: begin
                state_next = mk_free ? gmg_pkg::ST_CARVE : gmg_pkg::ST_PURGE_ISSUE;
            end
            gmg_pkg::ST_CARVE: state_next = gmg_pkg::ST_CARVE_WALL;
            gmg_pkg::ST_CARVE_WALL: begin
                state_next = (job_reg == gmg_pkg::JOB_DFS) ? gmg_pkg::ST_FINISH
                                                           : gmg_pkg::ST_NB_ISSUE;
            end
            gmg_pkg::ST_PURGE_ISSUE: begin
                state_next = idx_lt ? gmg_pkg::ST_PURGE_MARK : gmg_pkg::ST_FINISH;
            end
            gmg_pkg::ST_PURGE_MARK: state_next = gmg_pkg::ST_PURGE_KEEP;
            gmg_pkg::ST_PURGE_KEEP: state_next = gmg_pkg::ST_PURGE_ISSUE;
            gmg_pkg::ST_READ:       state_next = gmg_pkg::ST_FINISH;
            gmg_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = gmg_pkg::ST_IDLE;
                end
            end
            default: state_next = gmg_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        job_next        = job_reg;
        from_reset_next = from_reset_reg;
        act_cols_next   = act_cols_reg;
        act_rows_next   = act_rows_reg;
        act_mode_next   = act_mode_reg;
        depth_next      = depth_reg;
        fcount_next     = fcount_reg;
        done_next       = done_reg;
        clr_next        = clr_reg;
        cur_c_next      = cur_c_reg;
        cur_r_next      = cur_r_reg;
        dir_next        = dir_reg;
        ncand_next      = ncand_reg;
        cand_next       = cand_reg;
        tgt_c_next      = tgt_c_reg;
        tgt_r_next      = tgt_r_reg;
        tdir_next       = tdir_reg;
        rv_next         = rv_reg;
        idx_next        = idx_reg;
        kept_next       = kept_reg;
        edge_next       = edge_reg;
        rd_ok_next      = rd_ok_reg;
        res_next        = res_reg;

        mk_we        = 1'b0;
        mk_waddr     = cell_addr(tgt_c_reg, tgt_r_reg);
        mk_wdata     = 2'b11;
        mk_raddr     = cell_addr(nb.col, nb.row);
        st_we        = 1'b0;
        st_waddr     = depth_reg[LIW-1:0];
        st_wdata     = {tgt_r_reg, tgt_c_reg};
        st_raddr     = depth_dec[LIW-1:0];
        fr_we        = 1'b0;
        fr_waddr     = fcount_reg[LIW-1:0];
        fr_wdata     = '{dir: dir_reg, row: nb.row, col: nb.col};
        fr_raddr     = idx_reg[LIW-1:0];
        mod_start    = 1'b0;
        mod_dividend = rv_reg;
        mod_divisor  = LCW'(ncand_reg);
        res_valid    = 1'b0;

        case (state_reg)
            gmg_pkg::ST_CLEAR: begin
                mk_we    = 1'b1;
                mk_waddr = clr_reg;
                mk_wdata = 2'b00;
                clr_next = clr_reg + AW'(1);
            end
            gmg_pkg::ST_INIT: begin
                mk_we       = 1'b1;
                mk_waddr    = cell_addr(CW'(1), RW'(1));
                mk_wdata    = 2'b11;
                st_we       = 1'b1;
                st_waddr    = '0;
                st_wdata    = {RW'(1), CW'(1)};
                depth_next  = LCW'(1);
                fcount_next = '0;
                done_next   = 1'b0;
                cur_c_next  = CW'(1);
                cur_r_next  = RW'(1);
                dir_next    = gmg_pkg::DIR_N;
                job_next    = gmg_pkg::JOB_INIT;
            end
            gmg_pkg::ST_IDLE: begin
                mk_raddr     = cell_addr(CW'(in_item.read_column), RW'(in_item.read_row));
                mod_dividend = in_item.random_value;
                mod_divisor  = fcount_reg;
                if (in_fire) begin
                    res_next   = '0;
                    rv_next    = in_item.random_value;
                    rd_ok_next = rd_in_grid;
                    case (in_item.opcode)
                        gmg_pkg::OP_STEP: begin
                            if (!done_reg) begin
                                if (act_mode_reg == gmg_pkg::MODE_DFS) begin
                                    job_next = gmg_pkg::JOB_DFS;
                                    if (depth_reg == '0) begin
                                        done_next = 1'b1;
                                    end
                                end else begin
                                    job_next = gmg_pkg::JOB_PRIM;
                                    if (fcount_reg == '0) begin
                                        done_next = 1'b1;
                                    end else begin
                                        mod_start = 1'b1;
                                    end
                                end
                            end
                        end
                        gmg_pkg::OP_RESTART: begin
                            act_cols_next   = clamp_cols(cfg.maze_width);
                            act_rows_next   = clamp_rows(cfg.maze_height);
                            act_mode_next   = cfg.algorithm_mode;
                            clr_next        = '0;
                            from_reset_next = 1'b0;
                        end
                        default: begin
                            rd_ok_next = rd_in_grid;
                        end
                    endcase
                end
            end
            gmg_pkg::ST_DFS_TOP: begin
                cur_c_next = st_rdata_reg[CW-1:0];
                cur_r_next = st_rdata_reg[CW+RW-1:CW];
                dir_next   = gmg_pkg::DIR_N;
                ncand_next = '0;
            end
            gmg_pkg::ST_NB_ISSUE: begin
                if (!nb.ok) begin
                    dir_next = gmg_pkg::dir_t'(dir_reg + 2'd1);
                end
            end
            gmg_pkg::ST_NB_CHECK: begin
                if (mk_free && job_reg != gmg_pkg::JOB_DFS) begin
                    idx_next = '0;
                end else begin
                    if (mk_free) begin
                        cand_next[ncand_reg[1:0]] = dir_reg;
                        ncand_next = ncand_reg + 3'd1;
                    end
                    dir_next = gmg_pkg::dir_t'(dir_reg + 2'd1);
                end
            end
            gmg_pkg::ST_DUP_ISSUE: begin
                if (!idx_lt) begin
                    if (fcount_reg < LCW'(LIST_DEPTH)) begin
                        fr_we       = 1'b1;
                        fcount_next = fcount_reg + LCW'(1);
                    end
                    dir_next = gmg_pkg::dir_t'(dir_reg + 2'd1);
                end
            end
            gmg_pkg::ST_DUP_CHECK: begin
                if (dup_hit) begin
                    dir_next = gmg_pkg::dir_t'(dir_reg + 2'd1);
                end else begin
                    idx_next = idx_reg + LCW'(1);
                end
            end
            gmg_pkg::ST_SCAN_END: begin
                if (job_reg == gmg_pkg::JOB_DFS) begin
                    if (ncand_reg == '0) begin
                        depth_next = depth_dec;
                        res_next.backtracked = 1'b1;
                    end else begin
                        mod_start = 1'b1;
                    end
                end
                idx_next  = '0;
                kept_next = '0;
            end
            gmg_pkg::ST_MOD_WAIT: begin
                fr_raddr = mod_rem[LIW-1:0];
                if (mod_done) begin
                    tgt_c_next = nb_pick.col;
                    tgt_r_next = nb_pick.row;
                    tdir_next  = pick_dir;
                    idx_next   = mod_rem + LCW'(1);
                end
            end
            gmg_pkg::ST_PRIM_EDGE: begin
                edge_next = fr_rdata_reg;
            end
            gmg_pkg::ST_SHIFT_ISSUE: begin
                mk_raddr = cell_addr(edge_reg.col, edge_reg.row);
                if (!idx_lt) begin
                    fcount_next = fcount_reg - LCW'(1);
                end
            end
            gmg_pkg::ST_SHIFT_WR: begin
                fr_we    = 1'b1;
                fr_waddr = idx_dec[LIW-1:0];
                fr_wdata = fr_rdata_reg;
                idx_next = idx_reg + LCW'(1);
            end
            gmg_pkg::ST_PRIM_CHK: begin
                tgt_c_next = edge_reg.col;
                tgt_r_next = edge_reg.row;
                tdir_next  = edge_reg.dir;
                idx_next   = '0;
                kept_next  = '0;
            end
            gmg_pkg::ST_CARVE: begin
                mk_we    = 1'b1;
                mk_waddr = cell_addr(tgt_c_reg, tgt_r_reg);
                mk_wdata = 2'b11;
                res_next.carved      = 1'b1;
                res_next.new_column  = gmg_pkg::POS_W'(tgt_c_reg);
                res_next.new_row     = gmg_pkg::POS_W'(tgt_r_reg);
                res_next.wall_column = gmg_pkg::POS_W'(wall_c);
                res_next.wall_row    = gmg_pkg::POS_W'(wall_r);
                if (job_reg == gmg_pkg::JOB_DFS && depth_reg < LCW'(LIST_DEPTH)) begin
                    st_we      = 1'b1;
                    depth_next = depth_reg + LCW'(1);
                end
            end
            gmg_pkg::ST_CARVE_WALL: begin
                mk_we      = 1'b1;
                mk_waddr   = cell_addr(wall_c, wall_r);
                mk_wdata   = 2'b01;
                cur_c_next = tgt_c_reg;
                cur_r_next = tgt_r_reg;
                dir_next   = gmg_pkg::DIR_N;
            end
            gmg_pkg::ST_PURGE_ISSUE: begin
                if (!idx_lt) begin
                    fcount_next = kept_reg;
                    if (kept_reg == '0) begin
                        done_next = 1'b1;
                    end
                end
            end
            gmg_pkg::ST_PURGE_MARK: begin
                edge_next = fr_rdata_reg;
                mk_raddr  = cell_addr(fr_rdata_reg.col, fr_rdata_reg.row);
            end
            gmg_pkg::ST_PURGE_KEEP: begin
                if (mk_free) begin
                    fr_we     = 1'b1;
                    fr_waddr  = kept_reg[LIW-1:0];
                    fr_wdata  = edge_reg;
                    kept_next = kept_reg + LCW'(1);
                end
                idx_next = idx_reg + LCW'(1);
            end
            gmg_pkg::ST_READ: begin
                res_next.cell_is_path = rd_ok_reg && mk_rdata_reg[gmg_pkg::MARK_PATH];
            end
            gmg_pkg::ST_FINISH: begin
                res_valid = out_free;
            end
            default: res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gmg_pkg::ST_CLEAR;
            job_reg        <= gmg_pkg::JOB_INIT;
            from_reset_reg <= 1'b1;
            act_cols_reg   <= clamp_cols(gmg_pkg::WIDTH_RESET);
            act_rows_reg   <= clamp_rows(gmg_pkg::HEIGHT_RESET);
            act_mode_reg   <= gmg_pkg::MODE_RESET;
            depth_reg      <= LCW'(1);
            fcount_reg     <= '0;
            done_reg       <= 1'b0;
            clr_reg        <= '0;
            dir_reg        <= gmg_pkg::DIR_N;
            ncand_reg      <= '0;
            idx_reg        <= '0;
            kept_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            job_reg        <= job_next;
            from_reset_reg <= from_reset_next;
            act_cols_reg   <= act_cols_next;
            act_rows_reg   <= act_rows_next;
            act_mode_reg   <= act_mode_next;
            depth_reg      <= depth_next;
            fcount_reg     <= fcount_next;
            done_reg       <= done_next;
            clr_reg        <= clr_next;
            dir_reg        <= dir_next;
            ncand_reg      <= ncand_next;
            idx_reg        <= idx_next;
            kept_reg       <= kept_next;
        end
        cur_c_reg <= cur_c_next;
        cur_r_reg <= cur_r_next;
        cand_reg  <= cand_next;
        tgt_c_reg <= tgt_c_next;
        tgt_r_reg <= tgt_r_next;
        tdir_reg  <= tdir_next;
        rv_reg    <= rv_next;
        edge_reg  <= edge_next;
        rd_ok_reg <= rd_ok_next;
        res_reg   <= res_next;
    end

    always_comb begin
        res_out          = res_reg;
        res_out.complete = done_reg;
    end

    `GMG_ASSERT_ALWAYS(a_fcount_bound, aclk, aresetn, fcount_reg <= LCW'(LIST_DEPTH), "frontier count past depth")
    `GMG_ASSERT_ALWAYS(a_depth_bound, aclk, aresetn, depth_reg <= LCW'(LIST_DEPTH), "stack depth past depth")
    `GMG_ASSERT_NEXT(a_accept_busy, aclk, aresetn, in_fire, state_reg != gmg_pkg::ST_IDLE, "accepted transaction left block idle")
    `GMG_ASSERT_SAME(a_result_room, aclk, aresetn, res_valid, out_free, "result issued without output room")

endmodule

// File: rtl/grid_maze_generator_top.sv
// ----------------------------------------------------------------------------
// grid_maze_generator_top
// Maze generator by depth-first backtracking or randomized Prim, one
// step per transaction.
//
//   channel  dir  content
//   s_       in   tuser: opcode; tdata: random_value, read_column, read_row
//   m_       out  tdata: carved, new/wall coords, backtracked, complete, cell
//   cfg_     in   register writes: width, height, mode
//
// A depth-first step that carves waits on the remainder unit; a Prim step
// shifts the frontier, scans it for duplicates once per free neighbor and
// purges visited edges, all through the single frontier memory. Reset and
// restart clear the cell memory with s_tready low. One transaction is in work
// at a time; the output register holds a result while the next transaction
// is taken.
// ----------------------------------------------------------------------------
module grid_maze_generator_top #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int LIST_DEPTH  = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // random_value[15:0], read_column[21:16], read_row[27:22]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // carved[0], new_column[6:1], new_row[12:7],
                                   // wall_column[18:13], wall_row[24:19],
                                   // backtracked[25], complete[26], cell_is_path[27]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_wdata
);

    gmg_pkg::cfg_t    cfg_reg, cfg_next;
    gmg_pkg::item_t   item;
    gmg_pkg::result_t res;
    gmg_pkg::result_t out_reg;
    logic             out_valid_reg, out_valid_next;
    logic             res_valid;
    logic             out_free;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                gmg_pkg::CFG_MAZE_WIDTH:     cfg_next.maze_width     = cfg_wdata;
                gmg_pkg::CFG_MAZE_HEIGHT:    cfg_next.maze_height    = cfg_wdata;
                gmg_pkg::CFG_ALGORITHM_MODE: cfg_next.algorithm_mode = cfg_wdata[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    assign item.opcode       = s_tuser;
    assign item.random_value = s_tdata[15:0];
    assign item.read_column  = s_tdata[21:16];
    assign item.read_row     = s_tdata[27:22];

    assign out_free       = !out_valid_reg || m_tready;
    assign out_valid_next = res_valid ? 1'b1 : (out_valid_reg && !m_tready);

    gmg_core #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .LIST_DEPTH  (LIST_DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .res_valid (res_valid),
        .out_free  (out_free),
        .res_out   (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.maze_width     <= gmg_pkg::WIDTH_RESET;
            cfg_reg.maze_height    <= gmg_pkg::HEIGHT_RESET;
            cfg_reg.algorithm_mode <= gmg_pkg::MODE_RESET;
            out_valid_reg          <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg};

endmodule
